/* rtl/core/srq_pkg.sv */
`default_nettype none

package srq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned IDX_BITS    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENTRY_BITS  = TAG_BITS + KEY_BITS;
  localparam int unsigned STATUS_BITS = 2;

  // In first-come mode every entry carries this key, so the ordered
  // insertion degenerates into a plain FIFO append.
  localparam logic [KEY_BITS-1:0] FCFS_KEY = KEY_BITS'(1);

  typedef enum logic [STATUS_BITS-1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  // Source of the queue-relative read offset.
  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_TAIL = 2'd1,
    RD_WALK = 2'd2
  } rd_src_e;

  typedef struct packed {
    logic    in_ready;
    logic    start_walk;
    logic    rd_en;
    rd_src_e rd_src;
    logic    shift;
    logic    write_new;
    logic    pop_done;
    logic    load_result;
    status_e res_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic    accepted;
    action_e action;
    logic    full;
    logic    empty;
    logic    larger;
    logic    pos_one;
    logic    out_free;
  } dp_status_t;

  // Physical slot of a queue position in the circular buffer.
  function automatic logic [IDX_BITS-1:0] phys_idx(input logic [IDX_BITS-1:0] head,
                                                   input logic [IDX_BITS-1:0] off);
    logic [IDX_BITS:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (IDX_BITS + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_BITS + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/srq_if.sv */
`default_nettype none

interface srq_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [srq_pkg::TAG_BITS-1:0]  request_tag;
  logic [srq_pkg::KEY_BITS-1:0]  file_bytes;

  modport source (output valid, action, request_tag, file_bytes, input ready);
  modport sink   (input valid, action, request_tag, file_bytes, output ready);
endinterface

interface srq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [srq_pkg::STATUS_BITS-1:0] status;
  logic [srq_pkg::TAG_BITS-1:0]  popped_tag;
  logic [srq_pkg::KEY_BITS-1:0]  popped_key;
  logic [srq_pkg::CNT_BITS-1:0]  occupancy;

  modport source (output valid, status, popped_tag, popped_key, occupancy, input ready);
  modport sink   (input valid, status, popped_tag, popped_key, occupancy, output ready);
endinterface

`default_nettype wire

/* rtl/core/srq_ram.sv */
`default_nettype none

module srq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/srq_ctrl.sv */
`default_nettype none

module srq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srq_pkg::dp_status_t status_i,
  output srq_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_WALK   = 6'b000100,
    S_PLACE  = 6'b001000,
    S_POPRD  = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  srq_pkg::status_e  res_q, res_d;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.res_status = res_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.accepted) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status_i.action == srq_pkg::ACT_PUSH) begin
          if (status_i.full) begin
            res_d   = srq_pkg::ST_FULL;
            state_d = S_FINISH;
          end else if (status_i.empty) begin
            cmd_o.start_walk = 1'b1;
            state_d          = S_PLACE;
          end else begin
            cmd_o.start_walk = 1'b1;
            cmd_o.rd_en      = 1'b1;
            cmd_o.rd_src     = srq_pkg::RD_TAIL;
            state_d          = S_WALK;
          end
        end else begin
          if (status_i.empty) begin
            res_d   = srq_pkg::ST_EMPTY;
            state_d = S_FINISH;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_src = srq_pkg::RD_HEAD;
            state_d      = S_POPRD;
          end
        end
      end
      S_WALK: begin
        // The entry read last cycle is compared with the new key.
        if (status_i.larger) begin
          cmd_o.shift = 1'b1;
          if (status_i.pos_one) begin
            state_d = S_PLACE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_src = srq_pkg::RD_WALK;
          end
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.write_new = 1'b1;
        res_d           = srq_pkg::ST_PUSHED;
        state_d         = S_FINISH;
      end
      S_POPRD: begin
        cmd_o.pop_done = 1'b1;
        res_d          = srq_pkg::ST_POPPED;
        state_d        = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= srq_pkg::ST_PUSHED;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/srq_datapath.sv */
`default_nettype none

module srq_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  srq_pkg::ctrl_cmd_t cmd_i,
  output srq_pkg::dp_status_t status_o,
  srq_req_if.sink            req,
  srq_rsp_if.source          rsp
);

  localparam int unsigned IW = srq_pkg::IDX_BITS;
  localparam int unsigned CW = srq_pkg::CNT_BITS;
  localparam int unsigned TW = srq_pkg::TAG_BITS;
  localparam int unsigned KW = srq_pkg::KEY_BITS;
  localparam int unsigned EW = srq_pkg::ENTRY_BITS;

  logic                        mode_q;
  srq_pkg::action_e            action_q;
  logic [TW-1:0]               new_tag_q;
  logic [KW-1:0]               new_key_q;
  logic [IW-1:0]               head_q;
  logic [CW-1:0]               count_q;
  logic [IW-1:0]               pos_q;
  logic [TW-1:0]               pop_tag_q;
  logic [KW-1:0]               pop_key_q;

  logic                        out_valid_q;
  srq_pkg::status_e            out_status_q;
  logic [TW-1:0]               out_tag_q;
  logic [KW-1:0]               out_key_q;
  logic [CW-1:0]               out_occ_q;

  logic                        accepted;
  logic [IW-1:0]               rd_off;
  logic [IW-1:0]               raddr;
  logic [IW-1:0]               waddr;
  logic                        we;
  logic [EW-1:0]               wdata;
  logic [EW-1:0]               rdata;
  logic [IW-1:0]               head_next;

  assign req.ready = cmd_i.in_ready;
  assign accepted  = req.valid & cmd_i.in_ready;

  always_comb begin
    unique case (cmd_i.rd_src)
      srq_pkg::RD_HEAD: rd_off = '0;
      srq_pkg::RD_TAIL: rd_off = count_q[IW-1:0] - IW'(1);
      srq_pkg::RD_WALK: rd_off = pos_q - IW'(1) - IW'(1);
      default:          rd_off = '0;
    endcase
  end

  assign raddr     = srq_pkg::phys_idx(head_q, rd_off);
  assign waddr     = srq_pkg::phys_idx(head_q, pos_q);
  assign we        = cmd_i.shift | cmd_i.write_new;
  assign wdata     = cmd_i.shift ? rdata : {new_tag_q, new_key_q};
  assign head_next = srq_pkg::phys_idx(head_q, IW'(1));

  srq_ram #(
    .WIDTH (EW),
    .DEPTH (srq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    status_o.accepted = accepted;
    status_o.action   = action_q;
    status_o.full     = (count_q == CW'(srq_pkg::QUEUE_DEPTH));
    status_o.empty    = (count_q == '0);
    status_o.larger   = (rdata[KW-1:0] > new_key_q);
    status_o.pos_one  = (pos_q == IW'(1));
    status_o.out_free = ~out_valid_q | rsp.ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.write_new) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.pop_done) begin
        count_q <= count_q - CW'(1);
        head_q  <= head_next;
      end
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accepted) begin
      action_q  <= srq_pkg::action_e'(req.action);
      new_tag_q <= req.request_tag;
      new_key_q <= mode_q ? req.file_bytes : srq_pkg::FCFS_KEY;
    end
    if (cmd_i.start_walk) begin
      pos_q <= count_q[IW-1:0];
    end else if (cmd_i.shift) begin
      pos_q <= pos_q - IW'(1);
    end
    if (cmd_i.pop_done) begin
      pop_tag_q <= rdata[EW-1:KW];
      pop_key_q <= rdata[KW-1:0];
    end
    if (cmd_i.load_result) begin
      out_status_q <= cmd_i.res_status;
      out_occ_q    <= count_q;
      if (cmd_i.res_status == srq_pkg::ST_POPPED) begin
        out_tag_q <= pop_tag_q;
        out_key_q <= pop_key_q;
      end else begin
        out_tag_q <= '0;
        out_key_q <= '0;
      end
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.status     = out_status_q;
  assign rsp.popped_tag = out_tag_q;
  assign rsp.popped_key = out_key_q;
  assign rsp.occupancy  = out_occ_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(srq_pkg::QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_no_write_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_new |-> count_q != CW'(srq_pkg::QUEUE_DEPTH))
    else $error("new entry written into a full queue");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_done |-> count_q != '0)
    else $error("head removed from an empty queue");

  a_shift_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> pos_q != '0)
    else $error("entry shifted past the head");

endmodule

`default_nettype wire

/* rtl/core/size_ordered_request_queue.sv */
// A push compares n entries (0 to QUEUE_DEPTH - 1) on the walk back from the
// tail, one entry per cycle on the RAM port. One item is in flight at a time;
// the next request is taken the cycle after the result is loaded into the
// output register.
// Reset (rst_ni low, asynchronous) empties the queue and selects first-come mode.
`default_nettype none

// Top level of the size-ordered request queue.
//
// Entries live in a circular buffer held in a single-port-read RAM. The
// head pointer makes a pop a single read. A push starts at the tail and
// walks toward the head: every cycle it compares the entry read in the
// previous cycle with the new key, and when that entry is larger it is
// moved one slot back while the next one is read. When a key that is
// not larger is found, or the head is reached, the new entry is written
// into the freed slot. Equal keys therefore stay in arrival order.
//
// The controller sequences the walk and the response; the datapath holds
// the pointers, the count, the item under work and the output register.
// The output register lets a finished result wait for its transfer while
// the controller returns to idle.
module size_ordered_request_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  srq_req_if.sink    req_i,
  srq_rsp_if.source  rsp_o
);

  srq_pkg::ctrl_cmd_t  cmd;
  srq_pkg::dp_status_t status;

  srq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  srq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .req         (req_i),
    .rsp         (rsp_o)
  );

endmodule

`default_nettype wire
